// File: hdl/leader_cluster_table_top_macros.svh
// assertion macros for the leader cluster table
`ifndef LEADER_CLUSTER_TABLE_TOP_MACROS_SVH
`define LEADER_CLUSTER_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define LCT_ASSERT_IMPLY(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("lct assertion failed");

// next-cycle implication
`define LCT_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("lct assertion failed");

`endif

// File: hdl/lct_pkg.sv
// package: constants, codes and control types of the leader cluster table
package lct_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int REPORT_MAX  = 4;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int K_W    = (REPORT_MAX > 1) ? $clog2(REPORT_MAX) : 1;
  localparam int KC_W   = $clog2(REPORT_MAX + 1);

  localparam int OP_W       = 2;
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 6;
  localparam int COORD_W    = 20;
  localparam int CENTRE_W   = 28;
  localparam int COUNT_W    = 16;
  localparam int RADIUS_W   = 32;
  localparam int MINPTS_W   = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int FRAC_SHIFT = 8;
  localparam int DIFF_W     = CENTRE_W + 1;
  localparam int STEP_W     = 11;
  localparam int PROD_W     = DIFF_W + STEP_W;
  localparam int STEP_SHIFT = 16;
  localparam int DX_W       = COORD_W + 1;
  localparam int SQ_W       = 2 * DX_W - 1;
  localparam int D2_W       = SQ_W + 1;
  localparam int ENTRY_W    = 2 * CENTRE_W + COUNT_W;

  localparam logic signed [STEP_W-1:0] STEP_NUM   = 11'sd655;
  localparam logic [COUNT_W-1:0]       COUNT_MAX  = '1;
  localparam logic [RADIUS_W-1:0]      RADIUS_RST = 32'd16384;
  localparam logic [MINPTS_W-1:0]      MINPTS_RST = 16'd5;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 1'd1;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RES_MATCH = 3'd0,
    RES_NEW   = 3'd1,
    RES_DROP  = 3'd2,
    RES_ENTRY = 3'd3,
    RES_EMPTY = 3'd4,
    RES_CLEAR = 3'd5
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     scan_start;
    logic     scan_run;
    logic     scan_ins;
    logic     upd_mul;
    logic     write_upd;
    logic     write_new;
    logic     used_clear;
    logic     rep_setup;
    logic     rep_rd;
    logic     rep_next;
    logic     out_load;
    res_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic full;
    logic qual_zero;
    logic rep_last;
    logic out_free;
  } status_t;

endpackage

// File: hdl/lct_req_if.sv
// interface: input transaction channel
interface lct_req_if;
  logic                                valid;
  logic                                ready;
  logic        [lct_pkg::OP_W-1:0]     op;
  logic signed [lct_pkg::COORD_W-1:0]  point_x;
  logic signed [lct_pkg::COORD_W-1:0]  point_y;

  modport source (output valid, op, point_x, point_y, input ready);
  modport sink (input valid, op, point_x, point_y, output ready);
endinterface

// File: hdl/lct_rsp_if.sv
// interface: result transaction channel
interface lct_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [lct_pkg::KIND_W-1:0]   kind;
  logic        [lct_pkg::SLOT_W-1:0]   slot;
  logic signed [lct_pkg::COORD_W-1:0]  center_x;
  logic signed [lct_pkg::COORD_W-1:0]  center_y;
  logic        [lct_pkg::COUNT_W-1:0]  members;
  logic                                created;
  logic                                dropped;
  logic                                last;

  modport source (output valid, kind, slot, center_x, center_y, members, created, dropped,
                  last, input ready);
  modport sink (input valid, kind, slot, center_x, center_y, members, created, dropped,
                last, output ready);
endinterface

// File: hdl/leader_cluster_table_top.sv
// top level: online leader clustering table of 2-D points
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    op, point_x, point_y
//   rsp      out  valid / ready    kind, slot, center_x, center_y, members, created,
//                                  dropped, last
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// insert: scans the stored entries, one read per cycle until a hit stops the scan
// report: a scan of all stored entries, then a read and a result per reported cluster
// clear: a pending result on rsp stalls the final step of the next transaction
// reset empties the table at once; no clearing pass is run
`include "leader_cluster_table_top_macros.svh"

module leader_cluster_table_top (
  input  logic                          clk,
  input  logic                          rst,
  lct_req_if.sink                       req,
  lct_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [lct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lct_pkg::CFG_W-1:0]     cfg_data
);

  lct_pkg::cmd_t    cmd;
  lct_pkg::status_t st;

  lct_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .st  (st),
    .cmd (cmd)
  );

  lct_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point_x   (req.point_x),
    .point_y   (req.point_y),
    .cmd       (cmd),
    .st        (st),
    .rsp       (rsp)
  );

  `LCT_ASSERT_IMPLY(a_load_free, clk, rst, cmd.out_load, st.out_free)
  `LCT_ASSERT_IMPLY(a_new_not_full, clk, rst, cmd.write_new, !st.full)
  `LCT_ASSERT_NEXT(a_start_busy, clk, rst, cmd.scan_start, !req.ready)

endmodule

// File: hdl/lct_ram.sv
// generic single-write, single-read ram with registered read
module lct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/lct_dp.sv
// datapath: config registers, cluster table, scan pipeline, report lists, result register
module lct_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lct_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [lct_pkg::COORD_W-1:0] point_x,
  input  logic signed [lct_pkg::COORD_W-1:0] point_y,
  input  lct_pkg::cmd_t                      cmd,
  output lct_pkg::status_t                   st,
  lct_rsp_if.source                          rsp
);

  logic [lct_pkg::RADIUS_W-1:0] radius_sq;
  logic [lct_pkg::MINPTS_W-1:0] min_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq <= lct_pkg::RADIUS_RST;
      min_count <= lct_pkg::MINPTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lct_pkg::REG_RADIUS_SQ:  radius_sq <= cfg_data[lct_pkg::RADIUS_W-1:0];
        lct_pkg::REG_MIN_POINTS: min_count <= cfg_data[lct_pkg::MINPTS_W-1:0];
        default: ;
      endcase
    end
  end

  // latched point
  logic signed [lct_pkg::COORD_W-1:0]  px;
  logic signed [lct_pkg::COORD_W-1:0]  py;
  logic signed [lct_pkg::CENTRE_W-1:0] px_q;
  logic signed [lct_pkg::CENTRE_W-1:0] py_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= point_x;
      py <= point_y;
    end
  end

  assign px_q = {px, {lct_pkg::FRAC_SHIFT{1'b0}}};
  assign py_q = {py, {lct_pkg::FRAC_SHIFT{1'b0}}};

  // fill count
  logic [lct_pkg::CNT_W-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.used_clear) begin
      used <= '0;
    end else if (cmd.write_new) begin
      used <= used + 1'b1;
    end
  end

  assign st.full = (used == lct_pkg::CNT_W'(lct_pkg::TABLE_DEPTH));

  // table memory
  logic                            ram_we;
  logic [lct_pkg::IDX_W-1:0]       ram_waddr;
  logic [lct_pkg::ENTRY_W-1:0]     ram_wdata;
  logic                            ram_re;
  logic [lct_pkg::IDX_W-1:0]       ram_raddr;
  logic [lct_pkg::ENTRY_W-1:0]     ram_rdata;

  lct_ram #(
    .WIDTH (lct_pkg::ENTRY_W),
    .DEPTH (lct_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic signed [lct_pkg::CENTRE_W-1:0] q_cx;
  logic signed [lct_pkg::CENTRE_W-1:0] q_cy;
  logic        [lct_pkg::COUNT_W-1:0]  q_cnt;

  assign q_cx  = ram_rdata[lct_pkg::ENTRY_W-1 -: lct_pkg::CENTRE_W];
  assign q_cy  = ram_rdata[lct_pkg::COUNT_W +: lct_pkg::CENTRE_W];
  assign q_cnt = ram_rdata[lct_pkg::COUNT_W-1:0];

  // scan pipeline: read, square, compare
  logic                               issuing;
  logic [lct_pkg::IDX_W-1:0]          rd_idx;
  logic                               s1_valid;
  logic [lct_pkg::IDX_W-1:0]          s1_idx;
  logic                               s2_valid;
  logic [lct_pkg::IDX_W-1:0]          s2_idx;
  logic signed [lct_pkg::CENTRE_W-1:0] s2_cx;
  logic signed [lct_pkg::CENTRE_W-1:0] s2_cy;
  logic [lct_pkg::COUNT_W-1:0]        s2_cnt;
  logic [lct_pkg::SQ_W-1:0]           sq_x;
  logic [lct_pkg::SQ_W-1:0]           sq_y;
  logic signed [lct_pkg::DX_W-1:0]    dx;
  logic signed [lct_pkg::DX_W-1:0]    dy;
  logic signed [2*lct_pkg::DX_W-1:0]  dx_sq;
  logic signed [2*lct_pkg::DX_W-1:0]  dy_sq;
  logic [lct_pkg::D2_W-1:0]           d2;
  logic                               advance;
  logic                               last_issue;

  assign dx = {q_cx[lct_pkg::CENTRE_W-1], q_cx[lct_pkg::CENTRE_W-1:lct_pkg::FRAC_SHIFT]}
            - {px[lct_pkg::COORD_W-1], px};
  assign dy = {q_cy[lct_pkg::CENTRE_W-1], q_cy[lct_pkg::CENTRE_W-1:lct_pkg::FRAC_SHIFT]}
            - {py[lct_pkg::COORD_W-1], py};
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  assign d2     = lct_pkg::D2_W'(sq_x) + lct_pkg::D2_W'(sq_y);
  assign st.hit = cmd.scan_ins && s2_valid && (d2 < lct_pkg::D2_W'(radius_sq));
  assign advance    = cmd.scan_run && !st.hit;
  assign last_issue = ((lct_pkg::CNT_W'(rd_idx) + lct_pkg::CNT_W'(1)) == used);
  assign st.scan_end = !issuing && !s1_valid && !s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      issuing  <= (used != '0);
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      if (issuing && last_issue) begin
        issuing <= 1'b0;
      end
      s1_valid <= issuing;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_idx <= '0;
    end else if (advance) begin
      if (issuing) begin
        rd_idx <= rd_idx + 1'b1;
      end
      s1_idx <= rd_idx;
      s2_idx <= s1_idx;
      s2_cx  <= q_cx;
      s2_cy  <= q_cy;
      s2_cnt <= q_cnt;
      sq_x   <= lct_pkg::SQ_W'(dx_sq);
      sq_y   <= lct_pkg::SQ_W'(dy_sq);
    end
  end

  // centre update
  logic signed [lct_pkg::DIFF_W-1:0]   diff_x;
  logic signed [lct_pkg::DIFF_W-1:0]   diff_y;
  logic signed [lct_pkg::PROD_W-1:0]   prod_x;
  logic signed [lct_pkg::PROD_W-1:0]   prod_y;
  logic signed [lct_pkg::CENTRE_W-1:0] ncx;
  logic signed [lct_pkg::CENTRE_W-1:0] ncy;
  logic [lct_pkg::COUNT_W-1:0]         ncnt;

  assign diff_x = {px_q[lct_pkg::CENTRE_W-1], px_q} - {s2_cx[lct_pkg::CENTRE_W-1], s2_cx};
  assign diff_y = {py_q[lct_pkg::CENTRE_W-1], py_q} - {s2_cy[lct_pkg::CENTRE_W-1], s2_cy};

  always_ff @(posedge clk) begin
    if (cmd.upd_mul) begin
      prod_x <= diff_x * lct_pkg::STEP_NUM;
      prod_y <= diff_y * lct_pkg::STEP_NUM;
    end
  end

  assign ncx  = s2_cx + lct_pkg::CENTRE_W'(prod_x >>> lct_pkg::STEP_SHIFT);
  assign ncy  = s2_cy + lct_pkg::CENTRE_W'(prod_y >>> lct_pkg::STEP_SHIFT);
  assign ncnt = (s2_cnt == lct_pkg::COUNT_MAX) ? s2_cnt : s2_cnt + 1'b1;

  // report lists: first qualifiers in slot order, and largest counts
  logic [lct_pkg::CNT_W-1:0]   qcount;
  logic [lct_pkg::KC_W-1:0]    nfirst;
  logic [lct_pkg::IDX_W-1:0]   first_idx [lct_pkg::REPORT_MAX];
  logic                        top_v     [lct_pkg::REPORT_MAX];
  logic [lct_pkg::COUNT_W-1:0] top_cnt   [lct_pkg::REPORT_MAX];
  logic [lct_pkg::IDX_W-1:0]   top_idx   [lct_pkg::REPORT_MAX];
  logic                        ge        [lct_pkg::REPORT_MAX];
  logic                        prev_ge   [lct_pkg::REPORT_MAX];
  logic                        sh_v      [lct_pkg::REPORT_MAX];
  logic [lct_pkg::COUNT_W-1:0] sh_cnt    [lct_pkg::REPORT_MAX];
  logic [lct_pkg::IDX_W-1:0]   sh_idx    [lct_pkg::REPORT_MAX];
  logic                        rep_proc;

  assign rep_proc = cmd.scan_run && !cmd.scan_ins && s1_valid && (q_cnt >= min_count);

  always_comb begin
    prev_ge[0] = 1'b1;
    sh_v[0]    = 1'b0;
    sh_cnt[0]  = q_cnt;
    sh_idx[0]  = s1_idx;
    for (int j = 0; j < lct_pkg::REPORT_MAX; j++) begin
      ge[j] = top_v[j] && (top_cnt[j] >= q_cnt);
    end
    for (int j = 1; j < lct_pkg::REPORT_MAX; j++) begin
      prev_ge[j] = ge[j-1];
      sh_v[j]    = top_v[j-1];
      sh_cnt[j]  = top_cnt[j-1];
      sh_idx[j]  = top_idx[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= '0;
      nfirst <= '0;
      for (int j = 0; j < lct_pkg::REPORT_MAX; j++) begin
        top_v[j] <= 1'b0;
      end
    end else if (cmd.scan_start) begin
      qcount <= '0;
      nfirst <= '0;
      for (int j = 0; j < lct_pkg::REPORT_MAX; j++) begin
        top_v[j] <= 1'b0;
      end
    end else if (rep_proc) begin
      qcount <= qcount + 1'b1;
      if (int'(nfirst) < lct_pkg::REPORT_MAX) begin
        nfirst <= nfirst + 1'b1;
      end
      for (int j = 0; j < lct_pkg::REPORT_MAX; j++) begin
        if (!ge[j]) begin
          top_v[j] <= prev_ge[j] | sh_v[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rep_proc) begin
      if (int'(nfirst) < lct_pkg::REPORT_MAX) begin
        first_idx[nfirst[lct_pkg::K_W-1:0]] <= s1_idx;
      end
      for (int j = 0; j < lct_pkg::REPORT_MAX; j++) begin
        if (!ge[j]) begin
          if (prev_ge[j]) begin
            top_cnt[j] <= q_cnt;
            top_idx[j] <= s1_idx;
          end else begin
            top_cnt[j] <= sh_cnt[j];
            top_idx[j] <= sh_idx[j];
          end
        end
      end
    end
  end

  // report walk
  logic                      use_top;
  logic [lct_pkg::KC_W-1:0]  rep_n;
  logic [lct_pkg::K_W-1:0]   rep_k;
  logic [lct_pkg::IDX_W-1:0] list_idx;

  always_ff @(posedge clk) begin
    if (cmd.rep_setup) begin
      use_top <= (int'(qcount) > lct_pkg::REPORT_MAX);
      rep_n   <= (int'(qcount) > lct_pkg::REPORT_MAX) ?
                 lct_pkg::KC_W'(lct_pkg::REPORT_MAX) : lct_pkg::KC_W'(qcount);
      rep_k   <= '0;
    end else if (cmd.rep_next) begin
      rep_k <= rep_k + 1'b1;
    end
  end

  assign list_idx     = use_top ? top_idx[rep_k] : first_idx[rep_k];
  assign st.rep_last  = ((lct_pkg::KC_W'(rep_k) + lct_pkg::KC_W'(1)) == rep_n);
  assign st.qual_zero = (qcount == '0);

  // memory port selection
  assign ram_we    = cmd.write_upd | cmd.write_new;
  assign ram_waddr = cmd.write_new ? used[lct_pkg::IDX_W-1:0] : s2_idx;
  assign ram_wdata = cmd.write_new ? {px_q, py_q, lct_pkg::COUNT_W'(1)} : {ncx, ncy, ncnt};
  assign ram_re    = (advance && issuing) || cmd.rep_rd;
  assign ram_raddr = cmd.rep_rd ? list_idx : rd_idx;

  // result register
  logic                                out_valid;
  lct_pkg::kind_t                      out_kind;
  logic [lct_pkg::SLOT_W-1:0]          out_slot;
  logic signed [lct_pkg::COORD_W-1:0]  out_cx;
  logic signed [lct_pkg::COORD_W-1:0]  out_cy;
  logic [lct_pkg::COUNT_W-1:0]         out_members;
  logic                                out_created;
  logic                                out_dropped;
  logic                                out_last;
  lct_pkg::kind_t                      out_kind_next;
  logic [lct_pkg::SLOT_W-1:0]          out_slot_next;
  logic signed [lct_pkg::COORD_W-1:0]  out_cx_next;
  logic signed [lct_pkg::COORD_W-1:0]  out_cy_next;
  logic [lct_pkg::COUNT_W-1:0]         out_members_next;
  logic                                out_created_next;
  logic                                out_dropped_next;
  logic                                out_last_next;

  assign st.out_free = !out_valid || rsp.ready;

  always_comb begin
    out_kind_next    = lct_pkg::KIND_INSERT;
    out_slot_next    = '0;
    out_cx_next      = '0;
    out_cy_next      = '0;
    out_members_next = '0;
    out_created_next = 1'b0;
    out_dropped_next = 1'b0;
    out_last_next    = 1'b1;
    case (cmd.out_sel)
      lct_pkg::RES_MATCH: begin
        out_slot_next    = lct_pkg::SLOT_W'(s2_idx);
        out_cx_next      = ncx[lct_pkg::CENTRE_W-1:lct_pkg::FRAC_SHIFT];
        out_cy_next      = ncy[lct_pkg::CENTRE_W-1:lct_pkg::FRAC_SHIFT];
        out_members_next = ncnt;
      end
      lct_pkg::RES_NEW: begin
        out_slot_next    = lct_pkg::SLOT_W'(used);
        out_cx_next      = px;
        out_cy_next      = py;
        out_members_next = lct_pkg::COUNT_W'(1);
        out_created_next = 1'b1;
      end
      lct_pkg::RES_DROP: begin
        out_dropped_next = 1'b1;
      end
      lct_pkg::RES_ENTRY: begin
        out_kind_next    = lct_pkg::KIND_ENTRY;
        out_slot_next    = lct_pkg::SLOT_W'(list_idx);
        out_cx_next      = q_cx[lct_pkg::CENTRE_W-1:lct_pkg::FRAC_SHIFT];
        out_cy_next      = q_cy[lct_pkg::CENTRE_W-1:lct_pkg::FRAC_SHIFT];
        out_members_next = q_cnt;
        out_last_next    = st.rep_last;
      end
      lct_pkg::RES_EMPTY: begin
        out_kind_next = lct_pkg::KIND_EMPTY;
      end
      lct_pkg::RES_CLEAR: begin
        out_kind_next = lct_pkg::KIND_CLEAR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind    <= out_kind_next;
      out_slot    <= out_slot_next;
      out_cx      <= out_cx_next;
      out_cy      <= out_cy_next;
      out_members <= out_members_next;
      out_created <= out_created_next;
      out_dropped <= out_dropped_next;
      out_last    <= out_last_next;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.kind     = out_kind;
  assign rsp.slot     = out_slot;
  assign rsp.center_x = out_cx;
  assign rsp.center_y = out_cy;
  assign rsp.members  = out_members;
  assign rsp.created  = out_created;
  assign rsp.dropped  = out_dropped;
  assign rsp.last     = out_last;

endmodule

// File: hdl/lct_ctrl.sv
// controller: sequences insert, report and clear over the datapath
module lct_ctrl (
  input  logic             clk,
  input  logic             rst,
  lct_req_if.sink          req,
  input  lct_pkg::status_t st,
  output lct_pkg::cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_INS_SCAN = 11'b000_0000_0010,
    S_INS_UPD1 = 11'b000_0000_0100,
    S_INS_UPD2 = 11'b000_0000_1000,
    S_INS_NEW  = 11'b000_0001_0000,
    S_INS_DROP = 11'b000_0010_0000,
    S_REP_SCAN = 11'b000_0100_0000,
    S_REP_NONE = 11'b000_1000_0000,
    S_REP_RD   = 11'b001_0000_0000,
    S_REP_OUT  = 11'b010_0000_0000,
    S_CLR      = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_sel = lct_pkg::RES_MATCH;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd.load = 1'b1;
          case (req.op)
            lct_pkg::OP_INSERT: begin
              cmd.scan_start = 1'b1;
              state_next     = S_INS_SCAN;
            end
            lct_pkg::OP_REPORT: begin
              cmd.scan_start = 1'b1;
              state_next     = S_REP_SCAN;
            end
            lct_pkg::OP_CLEAR: state_next = S_CLR;
            default: ;
          endcase
        end
      end
      S_INS_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.scan_ins = 1'b1;
        if (st.hit) begin
          state_next = S_INS_UPD1;
        end else if (st.scan_end) begin
          state_next = st.full ? S_INS_DROP : S_INS_NEW;
        end
      end
      S_INS_UPD1: begin
        cmd.upd_mul = 1'b1;
        state_next  = S_INS_UPD2;
      end
      S_INS_UPD2: begin
        if (st.out_free) begin
          cmd.write_upd = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_sel   = lct_pkg::RES_MATCH;
          state_next    = S_IDLE;
        end
      end
      S_INS_NEW: begin
        if (st.out_free) begin
          cmd.write_new = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_sel   = lct_pkg::RES_NEW;
          state_next    = S_IDLE;
        end
      end
      S_INS_DROP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = lct_pkg::RES_DROP;
          state_next   = S_IDLE;
        end
      end
      S_REP_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_end) begin
          cmd.rep_setup = 1'b1;
          state_next    = st.qual_zero ? S_REP_NONE : S_REP_RD;
        end
      end
      S_REP_NONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = lct_pkg::RES_EMPTY;
          state_next   = S_IDLE;
        end
      end
      S_REP_RD: begin
        cmd.rep_rd = 1'b1;
        state_next = S_REP_OUT;
      end
      S_REP_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = lct_pkg::RES_ENTRY;
          if (st.rep_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rep_next = 1'b1;
            state_next   = S_REP_RD;
          end
        end
      end
      S_CLR: begin
        if (st.out_free) begin
          cmd.used_clear = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_sel    = lct_pkg::RES_CLEAR;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
